[sv/lct_pkg.sv]
// Shared constants, field codes and controller/datapath command types
// for the load-cell tare and scale block. No dependencies.
package lct_pkg;

    localparam int MAX_TARE_SAMPLES = 64;

    localparam int RAW_W      = 24;
    localparam int DIFF_W     = RAW_W + 1;
    localparam int GAIN_W     = 32;
    localparam int THRESH_W   = 25;
    localparam int WEIGHT_W   = 48;
    localparam int PROD_W     = DIFF_W + GAIN_W;
    localparam int SHIFT      = 8;
    localparam int SH_W       = PROD_W - SHIFT;
    localparam int CNT_W      = $clog2(MAX_TARE_SAMPLES + 1);
    localparam int SUM_W      = RAW_W + CNT_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_MEASURE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TARE       = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TARE_FINAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 32'd65536000;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 25'd500;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_start;
        logic div_step;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic final_tare;
    } t_dp_status;

endpackage

[sv/lct_ifs.sv]
// Handshake channel interfaces: sample input, result output and
// register write. Depends on lct_pkg.
interface lct_in_if;
    logic                           valid;
    logic                           ready;
    logic [lct_pkg::ACT_W-1:0]      action;
    logic [lct_pkg::RAW_W-1:0]      raw_code;

    modport source (output valid, action, raw_code, input ready);
    modport sink   (input valid, action, raw_code, output ready);
endinterface

interface lct_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lct_pkg::RAW_W-1:0]   raw_value;
    logic signed [lct_pkg::WEIGHT_W-1:0] weight;
    logic                               fresh;
    logic                               stable;
    logic                               tare_done;

    modport source (output valid, raw_value, weight, fresh, stable, tare_done,
                    input ready);
    modport sink   (input valid, raw_value, weight, fresh, stable, tare_done,
                    output ready);
endinterface

interface lct_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lct_pkg::CFG_IDX_W-1:0]      index;
    logic [lct_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/lct_dp.sv]
// Datapath: config registers, tare accumulator, restoring divider,
// weight multiplier and result registers. Depends on lct_pkg.
module lct_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lct_pkg::t_dp_cmd                  i_cmd,
    output lct_pkg::t_dp_status               o_status,
    input  logic                              i_cfg_we,
    input  logic [lct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [lct_pkg::ACT_W-1:0]         i_action,
    input  logic [lct_pkg::RAW_W-1:0]         i_raw_code,
    output logic signed [lct_pkg::RAW_W-1:0]  o_raw_value,
    output logic signed [lct_pkg::WEIGHT_W-1:0] o_weight,
    output logic                              o_fresh,
    output logic                              o_stable,
    output logic                              o_tare_done
);

    logic signed [lct_pkg::GAIN_W-1:0]   r_gain;
    logic [lct_pkg::THRESH_W-1:0]        r_thresh;
    logic [lct_pkg::ACT_W-1:0]           r_action;
    logic signed [lct_pkg::RAW_W-1:0]    r_raw;
    logic signed [lct_pkg::PROD_W-1:0]   r_prod;
    logic signed [lct_pkg::RAW_W-1:0]    r_offset;
    logic signed [lct_pkg::RAW_W-1:0]    r_prev;
    logic                                r_stable;
    logic signed [lct_pkg::SUM_W-1:0]    r_tare_sum;
    logic [lct_pkg::CNT_W-1:0]           r_tare_cnt;
    logic [lct_pkg::SUM_W-1:0]           r_div_num;
    logic [lct_pkg::CNT_W-1:0]           r_div_rem;
    logic                                r_div_neg;
    logic signed [lct_pkg::RAW_W-1:0]    r_out_raw;
    logic signed [lct_pkg::WEIGHT_W-1:0] r_out_weight;
    logic                                r_out_fresh;
    logic                                r_out_stable;
    logic                                r_out_done;

    logic signed [lct_pkg::DIFF_W-1:0]   w_diff;
    logic signed [lct_pkg::PROD_W-1:0]   w_prod;
    logic signed [lct_pkg::DIFF_W-1:0]   w_delta;
    logic [lct_pkg::DIFF_W-1:0]          w_abs;
    logic                                w_is_stable;
    logic [lct_pkg::CNT_W:0]             w_rem_sh;
    logic                                w_rem_ge;
    logic [lct_pkg::SUM_W-1:0]           w_quot;
    logic signed [lct_pkg::SH_W-1:0]     w_sh;
    logic [lct_pkg::SH_W-lct_pkg::WEIGHT_W:0] w_top;
    logic signed [lct_pkg::WEIGHT_W-1:0] w_weight;
    logic                                w_tare_room;
    logic                                w_is_tare;

    // weight product, raw minus offset at 25 bits
    assign w_diff = lct_pkg::DIFF_W'(r_raw) - lct_pkg::DIFF_W'(r_offset);
    assign w_prod = lct_pkg::PROD_W'(w_diff) * lct_pkg::PROD_W'(r_gain);

    // stability check against the previous sample
    assign w_delta     = lct_pkg::DIFF_W'(r_raw) - lct_pkg::DIFF_W'(r_prev);
    assign w_abs       = w_delta[lct_pkg::DIFF_W-1] ? lct_pkg::DIFF_W'(-w_delta)
                                                    : lct_pkg::DIFF_W'(w_delta);
    assign w_is_stable = (w_abs <= r_thresh);

    // arithmetic shift keeps the floor; clamp to the output width
    assign w_sh  = r_prod[lct_pkg::PROD_W-1:lct_pkg::SHIFT];
    assign w_top = w_sh[lct_pkg::SH_W-1:lct_pkg::WEIGHT_W-1];
    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            w_weight = w_sh[lct_pkg::WEIGHT_W-1:0];
        end else if (w_sh[lct_pkg::SH_W-1]) begin
            w_weight = {1'b1, {(lct_pkg::WEIGHT_W-1){1'b0}}};
        end else begin
            w_weight = {1'b0, {(lct_pkg::WEIGHT_W-1){1'b1}}};
        end
    end

    // one quotient bit per step
    assign w_rem_sh = {r_div_rem, r_div_num[lct_pkg::SUM_W-1]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_tare_cnt});
    assign w_quot   = r_div_neg ? (~r_div_num + 1'b1) : r_div_num;

    assign w_tare_room = (r_tare_cnt < lct_pkg::CNT_W'(lct_pkg::MAX_TARE_SAMPLES));
    assign w_is_tare   = (r_action == lct_pkg::ACT_TARE) ||
                         (r_action == lct_pkg::ACT_TARE_FINAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= lct_pkg::GAIN_RESET;
            r_thresh   <= lct_pkg::THRESH_RESET;
            r_offset   <= '0;
            r_prev     <= '0;
            r_stable   <= 1'b0;
            r_tare_sum <= '0;
            r_tare_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lct_pkg::CFG_GAIN:   r_gain   <= i_cfg_data;
                    lct_pkg::CFG_THRESH: r_thresh <= i_cfg_data[lct_pkg::THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.mul && w_is_tare && w_tare_room) begin
                r_tare_sum <= r_tare_sum + lct_pkg::SUM_W'(r_raw);
                r_tare_cnt <= r_tare_cnt + 1'b1;
            end
            if (i_cmd.load) begin
                case (r_action)
                    lct_pkg::ACT_MEASURE: begin
                        r_stable <= w_is_stable;
                        r_prev   <= r_raw;
                    end
                    lct_pkg::ACT_TARE_FINAL: begin
                        r_offset   <= w_quot[lct_pkg::RAW_W-1:0];
                        r_prev     <= w_quot[lct_pkg::RAW_W-1:0];
                        r_stable   <= 1'b0;
                        r_tare_sum <= '0;
                        r_tare_cnt <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_raw    <= i_raw_code;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_start) begin
            r_div_neg <= r_tare_sum[lct_pkg::SUM_W-1];
            r_div_num <= r_tare_sum[lct_pkg::SUM_W-1] ? lct_pkg::SUM_W'(-r_tare_sum)
                                                      : lct_pkg::SUM_W'(r_tare_sum);
            r_div_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (w_rem_ge) begin
                r_div_rem <= lct_pkg::CNT_W'(w_rem_sh - {1'b0, r_tare_cnt});
                r_div_num <= {r_div_num[lct_pkg::SUM_W-2:0], 1'b1};
            end else begin
                r_div_rem <= w_rem_sh[lct_pkg::CNT_W-1:0];
                r_div_num <= {r_div_num[lct_pkg::SUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load) begin
            r_out_raw    <= r_raw;
            r_out_weight <= '0;
            r_out_fresh  <= 1'b0;
            r_out_done   <= 1'b0;
            r_out_stable <= r_stable;
            case (r_action)
                lct_pkg::ACT_MEASURE: begin
                    r_out_weight <= w_weight;
                    r_out_fresh  <= 1'b1;
                    r_out_stable <= w_is_stable;
                end
                lct_pkg::ACT_TARE_FINAL: begin
                    r_out_done   <= 1'b1;
                    r_out_stable <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_status.final_tare = (r_action == lct_pkg::ACT_TARE_FINAL);
    assign o_raw_value = r_out_raw;
    assign o_weight    = r_out_weight;
    assign o_fresh     = r_out_fresh;
    assign o_stable    = r_out_stable;
    assign o_tare_done = r_out_done;

    a_cnt_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tare_cnt <= lct_pkg::CNT_W'(lct_pkg::MAX_TARE_SAMPLES))
        else $error("tare count beyond cap");

endmodule

[sv/lct_ctrl.sv]
// Controller state machine: sequences capture, multiply, divide and
// result load, and owns the output valid flag. Depends on lct_pkg.
module lct_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  lct_pkg::t_dp_status  i_status,
    output lct_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_START,
        S_DIV,
        S_WAIT
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [lct_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [lct_pkg::DIV_CNT_W-1:0] n_cnt;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          w_last_step;
    logic                          w_slot_free;

    assign w_last_step = (r_cnt == lct_pkg::DIV_CNT_W'(lct_pkg::SUM_W - 1));
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DIV_START);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.load      = (r_state == S_WAIT) && w_slot_free;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = i_status.final_tare ? S_DIV_START : S_WAIT;
            end
            S_DIV_START: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (w_last_step) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_capture_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MUL))
        else $error("accepted item did not enter multiply");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_last_step) |=> (r_state == S_WAIT))
        else $error("divider did not finish after full step count");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result load did not raise output valid");

endmodule

[sv/load_cell_tare_scale_stability.sv]
// Top level of the load-cell tare and scale block: joins controller and
// datapath to the channel interfaces. Depends on lct_pkg, lct_ifs, lct_ctrl, lct_dp.
//
// Each item on i_in is one converter sample: action 0 is a measure sample,
// 1 a tare sample, 2 the last tare sample (3 is passed through with no
// effect on state). One result item leaves on o_out for every item taken.
// A measure or plain tare item passes from acceptance to its result being
// shown through capture, one registered 25x32 multiply and result load. The
// last tare sample adds a divider start step and the offset average, done by
// the restoring divider, which retires one quotient bit per cycle over the
// 31-bit tare sum. i_in.ready is high while the block
// is idle; a finished result sits in the output register, so the next item
// can be taken while the previous result is still waiting on o_out. A result
// is only loaded once that register is free. Register writes on i_cfg are
// always ready and must only be issued while the block is idle: index 0 is
// the signed Q16.16 gain, index 1 the stability threshold; other indices
// are ignored. Weight is (raw - offset) * gain, shifted right 8 with floor
// rounding and clamped to 48 bits; it reads 0 on items that are not
// measure samples.
module load_cell_tare_scale_stability (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lct_in_if.sink          i_in,
    lct_out_if.source       o_out,
    lct_cfg_if.sink         i_cfg
);

    lct_pkg::t_dp_cmd    w_cmd;
    lct_pkg::t_dp_status w_status;
    logic                w_cfg_we;

    // register writes need no back-pressure
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    lct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lct_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_action    (i_in.action),
        .i_raw_code  (i_in.raw_code),
        .o_raw_value (o_out.raw_value),
        .o_weight    (o_out.weight),
        .o_fresh     (o_out.fresh),
        .o_stable    (o_out.stable),
        .o_tare_done (o_out.tare_done)
    );

endmodule

[dv/lct_weight_checker.sv]
`timescale 1ns / 1ps
// Checker for the load-cell tare and scale block: watches the sample, result
// and register channels, predicts every result and compares it.
// Depends on lct_pkg and lct_ifs.
module lct_weight_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lct_in_if    in_ch,
    lct_out_if   out_ch,
    lct_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_compared
);

    localparam longint WEIGHT_MAX = (longint'(1) <<< (lct_pkg::WEIGHT_W - 1)) - 1;
    localparam longint WEIGHT_MIN = -(longint'(1) <<< (lct_pkg::WEIGHT_W - 1));

    typedef struct {
        logic signed [lct_pkg::RAW_W-1:0]    raw_value;
        logic signed [lct_pkg::WEIGHT_W-1:0] weight;
        logic                                fresh;
        logic                                stable;
        logic                                tare_done;
    } t_reading;

    // predictor copy of the registers and state
    logic signed [lct_pkg::GAIN_W-1:0] gain_q16;
    logic [lct_pkg::THRESH_W-1:0]      stable_thresh;
    logic signed [lct_pkg::RAW_W-1:0]  tare_offset;
    logic signed [lct_pkg::RAW_W-1:0]  last_raw;
    logic                              stable_flag;
    logic signed [lct_pkg::SUM_W-1:0]  tare_sum;
    logic [lct_pkg::CNT_W-1:0]         tare_count;

    t_reading expected_readings[$];
    t_reading want;
    int       fails;
    int       compared;

    function automatic t_reading scale_sample(input logic [lct_pkg::ACT_W-1:0] act,
                                              input logic [lct_pkg::RAW_W-1:0] code);
        t_reading                         r;
        logic signed [lct_pkg::RAW_W-1:0] raw;
        longint                           delta;
        longint                           w;
        longint                           avg;
        raw         = code;
        r.raw_value = raw;
        r.weight    = '0;
        r.fresh     = 1'b0;
        r.tare_done = 1'b0;
        case (act)
            lct_pkg::ACT_MEASURE: begin
                delta = longint'(raw) - longint'(last_raw);
                if (delta < 0) delta = -delta;
                stable_flag = (delta <= longint'(stable_thresh));
                last_raw    = raw;
                // arithmetic shift floors, as the block does
                w = ((longint'(raw) - longint'(tare_offset)) * longint'(gain_q16))
                    >>> lct_pkg::SHIFT;
                if (w > WEIGHT_MAX) w = WEIGHT_MAX;
                else if (w < WEIGHT_MIN) w = WEIGHT_MIN;
                r.weight = w[lct_pkg::WEIGHT_W-1:0];
                r.fresh  = 1'b1;
            end
            lct_pkg::ACT_TARE, lct_pkg::ACT_TARE_FINAL: begin
                if (tare_count < lct_pkg::MAX_TARE_SAMPLES) begin
                    tare_sum   = tare_sum + raw;
                    tare_count = tare_count + 1'b1;
                end
                if (act == lct_pkg::ACT_TARE_FINAL) begin
                    // signed division truncates toward zero
                    avg         = longint'(tare_sum) / longint'(tare_count);
                    tare_offset = avg[lct_pkg::RAW_W-1:0];
                    last_raw    = avg[lct_pkg::RAW_W-1:0];
                    stable_flag = 1'b0;
                    tare_sum    = '0;
                    tare_count  = '0;
                    r.tare_done = 1'b1;
                end
            end
            default: ;
        endcase
        r.stable = stable_flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_q16      = lct_pkg::GAIN_RESET;
            stable_thresh = lct_pkg::THRESH_RESET;
            tare_offset   = '0;
            last_raw      = '0;
            stable_flag   = 1'b0;
            tare_sum      = '0;
            tare_count    = '0;
            expected_readings.delete();
            fails         = 0;
            compared      = 0;
        end else begin
            // results first: a result leaving now belongs to an older item
            if (out_ch.valid && out_ch.ready) begin
                if (expected_readings.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] unexpected result: raw %0d weight %0d",
                                 $time, out_ch.raw_value, out_ch.weight);
                end else begin
                    want = expected_readings.pop_front();
                    compared++;
                    if (out_ch.raw_value !== want.raw_value || out_ch.weight !== want.weight ||
                        out_ch.fresh !== want.fresh || out_ch.stable !== want.stable ||
                        out_ch.tare_done !== want.tare_done) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] mismatch (exp/act): raw %0d/%0d weight %0d/%0d",
                                     $time, want.raw_value, out_ch.raw_value,
                                     want.weight, out_ch.weight);
                            $display("    fresh %0b/%0b stable %0b/%0b tare_done %0b/%0b",
                                     want.fresh, out_ch.fresh,
                                     want.stable, out_ch.stable,
                                     want.tare_done, out_ch.tare_done);
                        end
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    lct_pkg::CFG_GAIN:   gain_q16      = cfg_ch.data;
                    lct_pkg::CFG_THRESH: stable_thresh = cfg_ch.data[lct_pkg::THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_readings.push_back(scale_sample(in_ch.action, in_ch.raw_code));
        end
        o_pending    <= expected_readings.size();
        o_fail_count <= fails;
        o_compared   <= compared;
    end

endmodule

[dv/load_cell_tare_scale_stability_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the load-cell tare and scale block: clock, reset,
// sample and register stimulus, output back-pressure and the verdict.
// Depends on lct_pkg, lct_ifs, the block itself and lct_weight_checker.
module load_cell_tare_scale_stability_tb;

    localparam logic [lct_pkg::ACT_W-1:0]     ACT_IGNORED = 2'd3;  // spare action code
    localparam logic [lct_pkg::CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;  // unmapped register index
    localparam int PHASE_ITEMS  = 190;
    localparam int N_PHASES     = 8;
    localparam int DRAIN_CYCLES = 40;       // settle time after the last result
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_TOGGLE, RX_CHOKED} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lct_in_if  in_ch ();
    lct_out_if out_ch ();
    lct_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int compared;

    // stimulus bookkeeping
    int                        n_measure, n_tare, n_final, n_ignored, n_settings;
    int                        burst_left;
    int                        cur_thresh;
    logic [lct_pkg::RAW_W-1:0] walk_code;
    int unsigned               cycle_count;

    // receiver stall pattern
    t_rx_mode rx_mode;
    int       rx_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    load_cell_tare_scale_stability u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lct_weight_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    // Output back-pressure: a mode is held for a random stretch, from no
    // stalls at all to ready only now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_mode      <= RX_OPEN;
            rx_left      <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                rx_left <= $urandom_range(20, 200);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   out_ch.ready <= 1'b1;
                RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_TOGGLE: out_ch.ready <= ~out_ch.ready;
                default:   out_ch.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int items_sent();
        return n_measure + n_tare + n_final;
    endfunction

    // Step between neighbouring samples: zero, exactly the threshold, one
    // past it, a spread around it, a step of up to 255, or something large.
    function automatic int jitter();
        int span;
        int step;
        span = (cur_thresh > (1 << 23)) ? (1 << 23) : cur_thresh;
        case ($urandom_range(0, 5))
            0:       step = 0;
            1:       step = span;
            2:       step = span + 1;
            3:       step = int'($urandom_range(0, 2 * span + 2)) - span - 1;
            4:       step = int'($urandom_range(0, 255));
            default: step = int'($urandom_range(0, (1 << 24) - 1));
        endcase
        if ($urandom_range(0, 1) == 1) step = -step;
        return step;
    endfunction

    // One item on the sample channel. valid stays high across a burst and
    // drops for a random gap once the burst runs out.
    task automatic send_sample(input logic [lct_pkg::ACT_W-1:0] act,
                               input logic [lct_pkg::RAW_W-1:0] code);
        int gap;
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.raw_code <= code;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        case (act)
            lct_pkg::ACT_MEASURE:    n_measure++;
            lct_pkg::ACT_TARE:       n_tare++;
            lct_pkg::ACT_TARE_FINAL: n_final++;
            default:                 n_ignored++;
        endcase
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every result is out, then let the block settle.
    task automatic wait_for_results(input int drain);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (drain) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lct_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [lct_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Only called with the block idle. Spare upper bits of the threshold
    // word and the unmapped index must both be ignored.
    task automatic apply_settings(input logic [lct_pkg::GAIN_W-1:0]   gain,
                                  input logic [lct_pkg::THRESH_W-1:0] thr);
        write_reg(lct_pkg::CFG_GAIN, gain);
        write_reg(lct_pkg::CFG_THRESH, {7'($urandom), thr});
        if ($urandom_range(0, 1) == 1) write_reg(CFG_SPARE, $urandom);
        cur_thresh = int'(thr);
        n_settings++;
    endtask

    // Mostly well-formed traffic: runs of measure samples drifting around a
    // level, and tare runs closed by a final tare sample (some long enough
    // to hit the sample cap). The rest is odd items and unfinished tares.
    task automatic random_traffic(input int quota);
        int                        goal;
        int                        len;
        int                        kind;
        int                        k;
        logic [lct_pkg::RAW_W-1:0] code;
        logic [lct_pkg::ACT_W-1:0] act;
        goal = items_sent() + quota;
        while (items_sent() < goal) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                len = $urandom_range(3, 30);
                if ($urandom_range(0, 4) == 0) walk_code = lct_pkg::RAW_W'($urandom);
                for (k = 0; k < len; k++) begin
                    walk_code = walk_code + lct_pkg::RAW_W'(jitter());
                    send_sample(lct_pkg::ACT_MEASURE, walk_code);
                end
            end else if (kind < 9) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 72)
                                                  : $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    code = ($urandom_range(0, 5) == 0) ? lct_pkg::RAW_W'($urandom)
                                                       : walk_code + lct_pkg::RAW_W'(jitter());
                    // now and then the closing sample never comes
                    act = (k == len - 1 && $urandom_range(0, 7) != 0) ? lct_pkg::ACT_TARE_FINAL
                                                                        : lct_pkg::ACT_TARE;
                    send_sample(act, code);
                end
            end else begin
                send_sample(lct_pkg::ACT_W'($urandom_range(0, 3)), lct_pkg::RAW_W'($urandom));
            end
            if ($urandom_range(0, 40) == 0) wait_for_results(0);
        end
    endtask

    initial begin
        logic [lct_pkg::GAIN_W-1:0]   gain;
        logic [lct_pkg::THRESH_W-1:0] thr;
        int                           phase;

        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.action   <= lct_pkg::ACT_MEASURE;
        in_ch.raw_code <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= lct_pkg::CFG_GAIN;
        cfg_ch.data    <= '0;
        walk_code       = '0;
        cur_thresh      = int'(lct_pkg::THRESH_RESET);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset settings (threshold 500).
        send_sample(lct_pkg::ACT_MEASURE, 24'h000000);     // no change from reset state
        send_sample(lct_pkg::ACT_MEASURE, 24'h7FFFFF);     // largest code
        send_sample(lct_pkg::ACT_MEASURE, 24'h800000);     // most negative code
        send_sample(lct_pkg::ACT_MEASURE, 24'hFFFFFF);     // -1
        send_sample(lct_pkg::ACT_MEASURE, 24'h0001F3);     // step equal to threshold
        send_sample(lct_pkg::ACT_MEASURE, 24'h0003E8);     // step one past threshold
        send_sample(ACT_IGNORED, 24'hABCDEF);              // spare action code
        send_sample(lct_pkg::ACT_TARE_FINAL, 24'h000100);  // tare of a single sample
        send_sample(lct_pkg::ACT_MEASURE, 24'h000100);
        send_sample(lct_pkg::ACT_TARE, 24'hFFFFFB);        // -5, 1, 2: average truncates to 0
        send_sample(lct_pkg::ACT_TARE, 24'h000001);
        send_sample(lct_pkg::ACT_TARE_FINAL, 24'h000002);
        send_sample(lct_pkg::ACT_MEASURE, 24'h000010);

        // Most negative gain against the widest differences.
        wait_for_results(DRAIN_CYCLES);
        apply_settings(32'h8000_0000, '1);
        send_sample(lct_pkg::ACT_TARE_FINAL, 24'h7FFFFF);
        send_sample(lct_pkg::ACT_MEASURE, 24'h800000);
        send_sample(lct_pkg::ACT_TARE, 24'h800000);
        send_sample(lct_pkg::ACT_TARE_FINAL, 24'h800000);
        send_sample(lct_pkg::ACT_MEASURE, 24'h7FFFFF);
        send_sample(ACT_IGNORED, 24'h000000);

        // Largest gain, zero threshold: only an unchanged sample is stable.
        wait_for_results(DRAIN_CYCLES);
        apply_settings(32'h7FFF_FFFF, '0);
        send_sample(lct_pkg::ACT_MEASURE, 24'h7FFFFF);
        send_sample(lct_pkg::ACT_MEASURE, 24'h7FFFFF);
        send_sample(lct_pkg::ACT_MEASURE, 24'h7FFFFE);

        // Random phases, each under its own register settings.
        for (phase = 0; phase < N_PHASES; phase++) begin
            wait_for_results(DRAIN_CYCLES);
            case (phase)
                0: begin gain = lct_pkg::GAIN_RESET; thr = lct_pkg::THRESH_RESET; end
                1: begin gain = '0;               thr = 25'd1; end
                2: begin gain = '1;               thr = '1; end
                3: begin gain = 32'd1;            thr = '0; end
                4: begin
                    gain = 32'h7FFF_FFFF;
                    thr  = lct_pkg::THRESH_W'($urandom_range(0, 4000));
                end
                5: begin
                    gain = 32'h8000_0000;
                    thr  = lct_pkg::THRESH_W'($urandom_range(0, 4000));
                end
                6: begin gain = $urandom;         thr = lct_pkg::THRESH_W'($urandom); end
                default: begin
                    gain = $urandom_range(0, 1 << 20);
                    thr  = lct_pkg::THRESH_W'($urandom_range(0, 4000));
                end
            endcase
            apply_settings(gain, thr);
            random_traffic(PHASE_ITEMS);
        end

        wait_for_results(DRAIN_CYCLES);
        $display("Covered %0d samples: %0d measure, %0d tare, %0d tare completions, %0d spare",
                 items_sent() + n_ignored, n_measure, n_tare, n_final, n_ignored);
        $display("%0d register settings, %0d results compared, %0d failures",
                 n_settings, compared, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[load_cell_tare_scale_stability.f]
sv/lct_pkg.sv
sv/lct_ifs.sv
sv/lct_dp.sv
sv/lct_ctrl.sv
sv/load_cell_tare_scale_stability.sv
dv/lct_weight_checker.sv
dv/load_cell_tare_scale_stability_tb.sv
